[rtl/core/eqd_pkg.sv]
// ----------------------------------------------------------------------------
// eqd_pkg
// Shared types and constants for the ECG QRS detector.
// ----------------------------------------------------------------------------
package eqd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_BEATS_AVG  = 3'd1;
    localparam logic [2:0] CFG_INT_WINDOW = 3'd2;
    localparam logic [2:0] CFG_REFRACTORY = 3'd3;
    localparam logic [2:0] CFG_PEAK_LEN   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register reset values
    localparam logic [7:0]  RST_THRESHOLD  = 8'd75;
    localparam logic [5:0]  RST_BEATS_AVG  = 6'd8;
    localparam logic [6:0]  RST_INT_WINDOW = 7'd50;
    localparam logic [11:0] RST_REFRACTORY = 12'd200;
    localparam logic [11:0] RST_PEAK_LEN   = 12'd1000;

    localparam int OUT_VAL_W = 36;
    localparam int BPM_W     = 16;
    localparam int RATE_NUM  = 600000;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [OUT_VAL_W-1:0] peak_average;
        logic [OUT_VAL_W-1:0] window_peak;
        logic [BPM_W-1:0]     bpm_tenths;
        logic                 beat_detected;
        logic [OUT_VAL_W-1:0] integrated;
    } t_result;

endpackage

[rtl/core/eqd_front.sv]
// ----------------------------------------------------------------------------
// eqd_front
// Input side: accepts sample beats and queues them for the back end.
// ----------------------------------------------------------------------------
module eqd_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_tvalid,
    output logic                    o_tready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_pop,
    output logic [SAMPLE_WIDTH-1:0] o_sample
);

    logic [SAMPLE_WIDTH-1:0] r_mem [2];
    logic                    r_wp, r_rp;
    logic [1:0]              r_cnt;
    logic                    w_push, w_pop;

    assign o_tready = (r_cnt != 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_sample = r_mem[r_rp];
    assign w_push   = i_tvalid && o_tready;
    assign w_pop    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            if (w_push && !w_pop) r_cnt <= r_cnt + 2'd1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

[rtl/core/eqd_div.sv]
// ----------------------------------------------------------------------------
// eqd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eqd_div #(
    parameter int NUMW = 48,
    parameter int DENW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_done,
    output logic [NUMW-1:0] o_quot
);

    localparam int CW = $clog2(NUMW + 1);

    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_rem, r_den;
    logic [CW-1:0]   r_cnt;
    logic            r_done;
    logic [DENW:0]   w_trial;
    logic            w_ge;

    assign w_trial = {r_rem, r_num[NUMW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quot  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_cnt <= CW'(NUMW);
            end else if (r_cnt != '0) begin
                r_rem <= w_ge ? DENW'(w_trial - {1'b0, r_den}) : w_trial[DENW-1:0];
                r_num <= {r_num[NUMW-2:0], w_ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) r_done <= 1'b1;
            end
        end
    end

endmodule

[rtl/core/eqd_back.sv]
// ----------------------------------------------------------------------------
// eqd_back
// Back end: derivative, square, integration, peak tracking, detection, rate.
// ----------------------------------------------------------------------------
module eqd_back
    import eqd_pkg::*;
#(
    parameter int MAX_WINDOW     = 64,
    parameter int MAX_BEATS      = 32,
    parameter int PEAK_HISTORY   = 5,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int WARMUP_SAMPLES = 3000
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg_wr                 i_cfg,
    input  logic                    i_valid,
    output logic                    o_pop,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_result                 o_result
);

    localparam int DW    = SAMPLE_WIDTH + 3;
    localparam int SQW   = 2 * DW;
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int RW    = $clog2(MAX_WINDOW);
    localparam int SUMW  = SQW + WW;
    localparam int PHW   = $clog2(PEAK_HISTORY + 1);
    localparam int PKW   = (PEAK_HISTORY > 1) ? $clog2(PEAK_HISTORY) : 1;
    localparam int PSW   = SQW + PHW;
    localparam int BCW   = $clog2(MAX_BEATS + 1);
    localparam int BAW   = $clog2(MAX_BEATS);
    localparam int RATEW = 20 + BCW;
    localparam int NUMW0 = (SUMW > PSW) ? SUMW : PSW;
    localparam int NUMW  = (NUMW0 > RATEW) ? NUMW0 : RATEW;
    localparam int DENW  = 32;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_PEAK  = 4'd4;
    localparam logic [3:0] S_DET   = 4'd5;
    localparam logic [3:0] S_RDF   = 4'd6;
    localparam logic [3:0] S_SPAN  = 4'd7;
    localparam logic [3:0] S_DIVR  = 4'd8;
    localparam logic [3:0] S_WEND  = 4'd9;
    localparam logic [3:0] S_PUSH  = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_DIVA  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state;

    // configuration
    logic [7:0]  r_thr;
    logic [5:0]  r_bfa;
    logic [6:0]  r_iw;
    logic [11:0] r_refr;
    logic [11:0] r_plen;

    // datapath state
    logic signed [SAMPLE_WIDTH-1:0] r_hist [4];
    logic [2:0]                     r_seen;
    logic signed [DW-1:0]           r_d;
    logic [SQW-1:0]                 r_sq, r_ring_q, r_integ;
    logic [RW-1:0]                  r_sq_wr;
    logic [WW-1:0]                  r_sq_cnt;
    logic [SUMW-1:0]                r_sum;
    logic [31:0]                    r_idx;
    logic [SQW-1:0]                 r_cur_peak, r_avg;
    logic [11:0]                    r_pwc;
    logic [SQW-1:0]                 r_ph [PEAK_HISTORY];
    logic [PHW-1:0]                 r_ph_cnt;
    logic [PKW-1:0]                 r_k;
    logic [PSW-1:0]                 r_acc;
    logic [BAW-1:0]                 r_bwr;
    logic [BCW-1:0]                 r_bcnt;
    logic [31:0]                    r_last, r_first;
    logic                           r_seeded;
    logic [BPM_W-1:0]               r_rate;
    logic                           r_beat, r_gap_ok;
    logic [SQW+7:0]                 r_pa, r_pb;
    logic                           r_out_valid;
    t_result                        r_out;

    // memories
    logic [SQW-1:0] m_ring [MAX_WINDOW];
    logic [31:0]    m_beat [MAX_BEATS];

    // divider
    logic            w_div_start, w_div_done;
    logic [NUMW-1:0] w_div_num, w_div_q;
    logic [DENW-1:0] w_div_den;

    // combinational helpers
    logic signed [DW-1:0] w_x, w_d;
    logic [WW-1:0]        w_win;
    logic [WW:0]          w_old_idx;
    logic [SUMW-1:0]      w_sum_n;
    logic [BCW-1:0]       w_keep, w_bcnt_inc, w_bcnt_trim;
    logic [BCW:0]         w_first_idx;
    logic [31:0]          w_span;
    logic [PSW-1:0]       w_acc_n;
    logic                 w_ring_rd, w_beat_we, w_beat_rd;
    logic [BAW-1:0]       w_bwr_inc;
    logic                 w_warm_done, w_out_free;
    logic [NUMW-1:0]      w_rate_q;

    assign w_x = DW'($signed(i_sample));
    assign w_d = (w_x <<< 1) + DW'(r_hist[0]) - DW'(r_hist[2]) - (DW'(r_hist[3]) <<< 1);

    always_comb begin
        if (r_iw == 7'd0) w_win = WW'(1);
        else if ({1'b0, r_iw} > (WW + 8)'(MAX_WINDOW)) w_win = WW'(MAX_WINDOW);
        else w_win = WW'(r_iw);
    end

    always_comb begin
        if ((WW + 1)'(r_sq_wr) >= (WW + 1)'(w_win)) w_old_idx = (WW + 1)'(r_sq_wr) - (WW + 1)'(w_win);
        else w_old_idx = (WW + 1)'(r_sq_wr) + (WW + 1)'(MAX_WINDOW) - (WW + 1)'(w_win);
    end

    assign w_sum_n = r_sum + SUMW'(r_sq) - SUMW'(r_ring_q);

    always_comb begin
        if (r_bfa < 6'd2) w_keep = BCW'(2);
        else if ((BCW + 6)'(r_bfa) > (BCW + 6)'(MAX_BEATS)) w_keep = BCW'(MAX_BEATS);
        else w_keep = BCW'(r_bfa);
    end

    assign w_bcnt_inc  = ((BCW + 1)'(r_bcnt) < (BCW + 1)'(MAX_BEATS)) ? r_bcnt + BCW'(1) : r_bcnt;
    assign w_bcnt_trim = (w_bcnt_inc > w_keep) ? w_keep : w_bcnt_inc;
    assign w_bwr_inc   = ((BAW + 1)'(r_bwr) == (BAW + 1)'(MAX_BEATS - 1)) ? '0 : r_bwr + BAW'(1);

    always_comb begin
        if ((BCW + 1)'(r_bwr) >= (BCW + 1)'(r_bcnt)) w_first_idx = (BCW + 1)'(r_bwr) - (BCW + 1)'(r_bcnt);
        else w_first_idx = (BCW + 1)'(r_bwr) + (BCW + 1)'(MAX_BEATS) - (BCW + 1)'(r_bcnt);
    end

    assign w_span      = r_idx - r_first;
    assign w_acc_n     = r_acc + PSW'(r_ph[r_k]);
    assign w_warm_done = (r_idx > 32'(WARMUP_SAMPLES));
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_rate_q    = w_div_q;

    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign w_ring_rd = o_pop;
    assign w_beat_we = ((r_state == S_DET) && w_warm_done && (r_pa > r_pb) && r_gap_ok)
                    || ((r_state == S_WEND) && (r_pwc >= r_plen) && !r_seeded);
    assign w_beat_rd = (r_state == S_RDF);

    // divider operand selection
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = NUMW'(w_sum_n);
        w_div_den   = DENW'(w_win);
        unique case (r_state)
            S_SUM: begin
                w_div_start = (r_sq_cnt >= w_win);
            end
            S_SPAN: begin
                w_div_start = (w_span != 32'd0);
                w_div_num   = NUMW'(RATEW'(RATE_NUM) * RATEW'(r_bcnt - BCW'(1)));
                w_div_den   = w_span;
            end
            S_ACC: begin
                w_div_start = ((PHW + PKW)'(r_k) == (PHW + PKW)'(r_ph_cnt - PHW'(1)));
                w_div_num   = NUMW'(w_acc_n);
                w_div_den   = DENW'(r_ph_cnt);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    eqd_div #(
        .NUMW(NUMW),
        .DENW(DENW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_done (w_div_done),
        .o_quot (w_div_q)
    );

    // square ring
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) m_ring[r_sq_wr] <= r_sq;
        if (w_ring_rd) r_ring_q <= m_ring[w_old_idx[RW-1:0]];
    end

    // beat time store
    always_ff @(posedge i_clk) begin
        if (w_beat_we) m_beat[r_bwr] <= r_idx;
        if (w_beat_rd) r_first <= m_beat[w_first_idx[BAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= RST_THRESHOLD;
            r_bfa       <= RST_BEATS_AVG;
            r_iw        <= RST_INT_WINDOW;
            r_refr      <= RST_REFRACTORY;
            r_plen      <= RST_PEAK_LEN;
            for (int j = 0; j < 4; j++) r_hist[j] <= '0;
            r_seen      <= '0;
            r_sq_wr     <= '0;
            r_sq_cnt    <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_cur_peak  <= '0;
            r_avg       <= '0;
            r_pwc       <= '0;
            r_ph_cnt    <= '0;
            r_bwr       <= '0;
            r_bcnt      <= '0;
            r_seeded    <= 1'b0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_OUT)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_hist[0] <= $signed(i_sample);
                        r_hist[1] <= r_hist[0];
                        r_hist[2] <= r_hist[1];
                        r_hist[3] <= r_hist[2];
                        r_d       <= w_d;
                        r_beat    <= 1'b0;
                        if (r_seen >= 3'd5) begin
                            r_state <= S_SQ;
                        end else begin
                            r_seen  <= r_seen + 3'd1;
                            r_integ <= '0;
                            r_state <= S_PEAK;
                        end
                    end
                end
                S_SQ: begin
                    r_sq    <= SQW'(r_d * r_d);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sq_wr <= ((RW + 1)'(r_sq_wr) == (RW + 1)'(MAX_WINDOW - 1)) ? '0
                             : r_sq_wr + RW'(1);
                    if (r_sq_cnt >= w_win) begin
                        r_sum   <= w_sum_n;
                        r_state <= S_DIVI;
                    end else begin
                        r_sum    <= r_sum + SUMW'(r_sq);
                        r_sq_cnt <= r_sq_cnt + WW'(1);
                        r_integ  <= r_sq;
                        r_state  <= S_PEAK;
                    end
                end
                S_DIVI: begin
                    if (w_div_done) begin
                        r_integ <= SQW'(w_div_q);
                        r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (r_integ > r_cur_peak) r_cur_peak <= r_integ;
                    if (r_pwc != 12'hFFF) r_pwc <= r_pwc + 12'd1;
                    r_pa     <= (SQW + 8)'(r_integ * 7'd100);
                    r_pb     <= (SQW + 8)'(r_avg * r_thr);
                    r_gap_ok <= (r_bcnt == '0) || ((r_idx - r_last) > 32'(r_refr));
                    r_state  <= S_DET;
                end
                S_DET: begin
                    if (w_beat_we) begin
                        r_beat  <= 1'b1;
                        r_bwr   <= w_bwr_inc;
                        r_bcnt  <= w_bcnt_trim;
                        r_last  <= r_idx;
                        r_state <= S_RDF;
                    end else begin
                        r_state <= S_WEND;
                    end
                end
                S_RDF: begin
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    r_state <= (w_span != 32'd0) ? S_DIVR : S_WEND;
                end
                S_DIVR: begin
                    if (w_div_done) begin
                        r_rate  <= (w_rate_q > NUMW'(16'hFFFF)) ? 16'hFFFF : w_rate_q[15:0];
                        r_state <= S_WEND;
                    end
                end
                S_WEND: begin
                    if (r_pwc >= ((r_plen == 12'd0) ? 12'd1 : r_plen)) begin
                        if (!r_seeded) begin
                            // warm-up: extra peak push and beat time seed
                            for (int j = PEAK_HISTORY - 1; j > 0; j--) r_ph[j] <= r_ph[j-1];
                            r_ph[0] <= r_cur_peak;
                            if ((PHW + 1)'(r_ph_cnt) < (PHW + 1)'(PEAK_HISTORY))
                                r_ph_cnt <= r_ph_cnt + PHW'(1);
                            if (w_warm_done) r_seeded <= 1'b1;
                            r_bwr  <= w_bwr_inc;
                            r_bcnt <= w_bcnt_inc;
                            r_last <= r_idx;
                        end
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PUSH: begin
                    for (int j = PEAK_HISTORY - 1; j > 0; j--) r_ph[j] <= r_ph[j-1];
                    r_ph[0] <= r_cur_peak;
                    if ((PHW + 1)'(r_ph_cnt) < (PHW + 1)'(PEAK_HISTORY))
                        r_ph_cnt <= r_ph_cnt + PHW'(1);
                    r_acc   <= '0;
                    r_k     <= '0;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= w_acc_n;
                    r_k   <= r_k + PKW'(1);
                    if (w_div_start) r_state <= S_DIVA;
                end
                S_DIVA: begin
                    if (w_div_done) begin
                        r_avg      <= SQW'(w_div_q);
                        r_cur_peak <= '0;
                        r_pwc      <= '0;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.integrated    <= OUT_VAL_W'(r_integ);
                        r_out.beat_detected <= r_beat;
                        r_out.bpm_tenths    <= r_rate;
                        r_out.window_peak   <= OUT_VAL_W'(r_cur_peak);
                        r_out.peak_average  <= OUT_VAL_W'(r_avg);
                        r_out_valid         <= 1'b1;
                        r_idx               <= r_idx + 32'd1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg.en) begin
                case (i_cfg.idx)
                    CFG_THRESHOLD:  r_thr  <= i_cfg.data[7:0];
                    CFG_BEATS_AVG:  r_bfa  <= i_cfg.data[5:0];
                    CFG_INT_WINDOW: begin
                        if (i_cfg.data[6:0] != r_iw) begin
                            r_sq_cnt <= '0;
                            r_sum    <= '0;
                        end
                        r_iw <= i_cfg.data[6:0];
                    end
                    CFG_REFRACTORY: r_refr <= i_cfg.data;
                    CFG_PEAK_LEN:   r_plen <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/core/ecg_qrs_detector.sv]
// ----------------------------------------------------------------------------
// ecg_qrs_detector
// QRS detector: slope, square, moving integration, peak averaging, heart rate.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   tdata: sample
//  m_axis    out        m_axis_tvalid/tready   tdata: results, tuser: beat flag
//  cfg       in         i_cfg_we               i_cfg_addr, i_cfg_data
//
//  a sample needs a pass of the shared serial divider for the integration once
//  the window is full; a beat adds the beat-time read and span states and, for
//  a nonzero span, another divider pass for the rate; a window end adds a push
//  state, an accumulate step per held peak and a divider pass for the average.
//  two-beat input queue and a registered output: input keeps being taken while
//  a result waits, until the queue is full. synchronous active-low reset
//  restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module ecg_qrs_detector
    import eqd_pkg::*;
#(
    parameter int MAX_WINDOW     = 64,
    parameter int MAX_BEATS      = 32,
    parameter int PEAK_HISTORY   = 5,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int WARMUP_SAMPLES = 3000
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,  // sample
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // integrated, bpm_tenths, window_peak, peak_average
    output logic [127:0]                          m_axis_tdata,
    output logic [0:0]                            m_axis_tuser,  // beat_detected
    input  logic                                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_data
);

    logic                    w_q_valid, w_q_pop;
    logic [SAMPLE_WIDTH-1:0] w_q_sample;
    t_cfg_wr                 w_cfg;
    t_result                 w_res;

    assign w_cfg.en   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_addr;
    assign w_cfg.data = i_cfg_data;

    eqd_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tvalid(s_axis_tvalid),
        .o_tready(s_axis_tready),
        .i_sample(s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_sample(w_q_sample)
    );

    eqd_back #(
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_BEATS     (MAX_BEATS),
        .PEAK_HISTORY  (PEAK_HISTORY),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .WARMUP_SAMPLES(WARMUP_SAMPLES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_q_valid),
        .o_pop   (w_q_pop),
        .i_sample(w_q_sample),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_result(w_res)
    );

    assign m_axis_tdata = {4'b0, w_res.peak_average, w_res.window_peak,
                           w_res.bpm_tenths, w_res.integrated};
    assign m_axis_tuser = w_res.beat_detected;

endmodule

[rtl/core/eqd_checker.sv]
// ----------------------------------------------------------------------------
// eqd_checker
// Port-level checks on the QRS detector, bound to the top level.
// ----------------------------------------------------------------------------
module eqd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a beat needs a nonzero integrated value
    a_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[35:0] != 36'd0)
        else $error("beat flagged with zero integrated value");

endmodule

bind ecg_qrs_detector eqd_checker u_eqd_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ECG QRS detector. A stream driver sends samples
// from a queue. A bit-accurate predictor of slope, square, integration, peak
// averaging and rate fills a queue of expected results. A monitor checks each
// output beat field by field. Both sides idle at random, and the receiver
// holds off once for a long stretch. Settings change between phases and
// cover the register extremes.
// ----------------------------------------------------------------------------
module tb_top;
    import eqd_pkg::*;

    localparam int LIMIT_CYCLES = 10000000;

    typedef struct {
        logic [35:0] integ;
        logic        beat;
        logic [15:0] bpm;
        logic [35:0] wpeak;
        logic [35:0] pavg;
    } t_qrs_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [127:0]          m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ecg_qrs_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [15:0] sample_q[$];
    t_qrs_out    expected_results[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    int          hold_req = 0;
    int          hold_done = 0;

    // predictor state
    int unsigned       thr_pct = 75, beats_avg = 8, int_win = 50;
    int unsigned       refr = 200, peak_len = 1000;
    longint signed     hist[4];
    int unsigned       seen, sq_cnt, sq_wr, smp_idx, pw_cnt, pk_cnt, bt_cnt, bt_wr;
    longint unsigned   sq_ring[64];
    longint unsigned   sq_sum, cur_peak, avg_peak;
    longint unsigned   pk_hist[5];
    int unsigned       beat_t[32];
    bit                seeded;
    int unsigned       rate;

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    task automatic queue_sample(input logic [15:0] v);
        sample_q.insert(sample_q.size(), v);
    endtask

    function automatic logic [15:0] next_sample();
        logic [15:0] v;
        v = sample_q[0];
        sample_q.delete(0);
        return v;
    endfunction

    function automatic t_qrs_out next_expected();
        t_qrs_out v;
        v = expected_results[0];
        expected_results.delete(0);
        return v;
    endfunction

    task automatic push_beat_time(input int unsigned t);
        beat_t[bt_wr] = t;
        bt_wr = (bt_wr + 1) % 32;
        if (bt_cnt < 32) bt_cnt++;
    endtask

    task automatic push_peak(input longint unsigned v);
        for (int k = 4; k > 0; k--) pk_hist[k] = pk_hist[k-1];
        pk_hist[0] = v;
        if (pk_cnt < 5) pk_cnt++;
    endtask

    task automatic predict_detector(input logic [15:0] raw);
        longint signed   x, d;
        longint unsigned sq, integ, sum;
        int unsigned     i, w, plen, keep, first, span, last, old;
        bit              beat, gap_ok;
        t_qrs_out        r;
        x = longint'($signed(raw));
        i = smp_idx;
        integ = 0;
        beat = 0;
        plen = (peak_len != 0) ? peak_len : 1;
        if (seen >= 5) begin
            d = 2*x + hist[0] - hist[2] - 2*hist[3];
            sq = d * d;
            w = (int_win < 1) ? 1 : ((int_win > 64) ? 64 : int_win);
            if (sq_cnt >= w) begin
                old = (sq_wr + 64 - w) % 64;
                sq_sum = sq_sum + sq - sq_ring[old];
                integ = sq_sum / w;
            end else begin
                sq_sum += sq;
                sq_cnt++;
                integ = sq;
            end
            sq_ring[sq_wr] = sq;
            sq_wr = (sq_wr + 1) % 64;
        end else begin
            seen++;
        end
        hist[3] = hist[2]; hist[2] = hist[1]; hist[1] = hist[0]; hist[0] = x;
        if (integ > cur_peak) cur_peak = integ;
        if (pw_cnt < 12'hFFF) pw_cnt++;
        if (i > 3000) begin
            gap_ok = 1;
            if (bt_cnt > 0) begin
                last = beat_t[(bt_wr + 31) % 32];
                gap_ok = (i - last) > refr;
            end
            if (integ * 100 > avg_peak * thr_pct && gap_ok) begin
                beat = 1;
                keep = (beats_avg < 2) ? 2 : ((beats_avg > 32) ? 32 : beats_avg);
                push_beat_time(i);
                if (bt_cnt > keep) bt_cnt = keep;
                first = beat_t[(bt_wr + 32 - bt_cnt) % 32];
                span = i - first;
                if (span != 0) begin
                    sum = (64'd600000 * (bt_cnt - 1)) / span;
                    rate = (sum > 65535) ? 65535 : int'(sum);
                end
            end
        end
        if (pw_cnt >= plen) begin
            if (!seeded) begin
                push_peak(cur_peak);
                if (i > 3000) seeded = 1;
                push_beat_time(i);
            end
            push_peak(cur_peak);
            sum = 0;
            for (int k = 0; k < pk_cnt; k++) sum += pk_hist[k];
            avg_peak = sum / pk_cnt;
            cur_peak = 0;
            pw_cnt = 0;
        end
        smp_idx = i + 1;
        r.integ = integ[35:0];
        r.beat  = beat;
        r.bpm   = rate[15:0];
        r.wpeak = cur_peak[35:0];
        r.pavg  = avg_peak[35:0];
        expected_results.insert(expected_results.size(), r);
    endtask

    // sample driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) predict_detector(s_axis_tdata);
        if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (i_rst_n && sample_q.size() > 0) begin
                s_axis_tdata  <= next_sample();
                s_axis_tvalid <= 1'b1;
                src_gap       <= gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with one long hold-off on request
    int snk_gap = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_cnt <= 3000;
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
            if (m_axis_tvalid && m_axis_tready) snk_gap <= gap_len();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_qrs_out e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                e = next_expected();
                if (m_axis_tdata[35:0] !== e.integ || m_axis_tuser[0] !== e.beat ||
                    m_axis_tdata[51:36] !== e.bpm || m_axis_tdata[87:52] !== e.wpeak ||
                    m_axis_tdata[123:88] !== e.pavg) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp integ=%0d beat=%0d bpm=%0d wpk=%0d avg=%0d",
                                 e.integ, e.beat, e.bpm, e.wpeak, e.pavg,
                                 " got integ=%0d beat=%0d bpm=%0d wpk=%0d avg=%0d",
                                 m_axis_tdata[35:0], m_axis_tuser[0], m_axis_tdata[51:36],
                                 m_axis_tdata[87:52], m_axis_tdata[123:88]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input int unsigned v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_data <= v[CFG_DATA_W-1:0];
        case (a)
            CFG_THRESHOLD:  thr_pct = v & 8'hFF;
            CFG_BEATS_AVG:  beats_avg = v & 6'h3F;
            CFG_INT_WINDOW: begin
                if ((v & 7'h7F) != int_win) begin
                    sq_cnt = 0;
                    sq_sum = 0;
                end
                int_win = v & 7'h7F;
            end
            CFG_REFRACTORY: refr = v & 12'hFFF;
            CFG_PEAK_LEN:   peak_len = v & 12'hFFF;
            default: ;
        endcase
    endtask

    task automatic set_all(input int unsigned t, b, w, rf, pl);
        write_reg(CFG_THRESHOLD, t);
        write_reg(CFG_BEATS_AVG, b);
        write_reg(CFG_INT_WINDOW, w);
        write_reg(CFG_REFRACTORY, rf);
        write_reg(CFG_PEAK_LEN, pl);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ecg-like stream: low noise baseline with sharp complexes, some wild noise
    task automatic add_ecg(input int n);
        int spacing, until_spike, k;
        spacing = $urandom_range(150, 900);
        until_spike = $urandom_range(5, spacing);
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_sample(16'($urandom));
            end else if (until_spike <= 0) begin
                k = $urandom_range(3000, 32767);
                queue_sample(16'(k));
                queue_sample(16'(-k));
                j++;
                until_spike = spacing + $urandom_range(0, 60) - 30;
            end else begin
                queue_sample(16'($urandom_range(0, 400) - 200));
                until_spike--;
            end
        end
    endtask

    initial begin
        seen = 0; sq_cnt = 0; sq_wr = 0; sq_sum = 0; smp_idx = 0; cur_peak = 0;
        pw_cnt = 0; pk_cnt = 0; avg_peak = 0; bt_cnt = 0; bt_wr = 0; seeded = 0;
        rate = 0;
        for (int k = 0; k < 4; k++) hist[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, steepest slopes, sign edges
        sample_q = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                     16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000,
                     16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hAAAA,
                     16'h5555, 16'h0000};
        add_ecg(200);
        wait_idle();

        set_all(0, 2, 1, 0, 1);
        add_ecg(150);
        wait_idle();

        set_all(255, 32, 64, 4095, 4095);
        hold_req = 1;
        no_idle = 1;
        add_ecg(200);
        wait_idle();
        no_idle = 0;

        set_all(75, 8, 0, 200, 0);
        add_ecg(120);
        wait_idle();

        set_all(50, 5, 20, 150, 300);
        add_ecg(250);
        wait_idle();

        set_all(0, 2, 1, 0, 1);
        add_ecg(100);
        wait_idle();

        set_all(255, 32, 64, 4095, 4095);
        add_ecg(100);
        wait_idle();

        set_all(100, 63, 127, 100, 500);
        add_ecg(150);
        wait_idle();

        set_all($urandom_range(0, 255), $urandom_range(2, 32), $urandom_range(1, 64),
                $urandom_range(0, 400), $urandom_range(1, 600));
        add_ecg(150);
        wait_idle();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
